// ===== sv/mbsp_pkg.sv =====
// Shared types and constants of the MIDI byte stream parser.
package mbsp_pkg;

    // Parser modes; codes above the last member behave as normal mode.
    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_QFRAME  = 3'd1,
        MODE_SYSEX   = 3'd2,
        MODE_SX_RT   = 3'd3,
        MODE_SX_MTC  = 3'd4,
        MODE_SX_FULL = 3'd5
    } t_mode;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_TC1,
        S_TC2,
        S_TC3,
        S_OUT_TC,
        S_OUT_EVT
    } t_state;

    // Result kinds.
    localparam logic [3:0] KIND_NOTE   = 4'd0;
    localparam logic [3:0] KIND_POLY   = 4'd1;
    localparam logic [3:0] KIND_CTRL   = 4'd2;
    localparam logic [3:0] KIND_PROG   = 4'd3;
    localparam logic [3:0] KIND_CPRESS = 4'd4;
    localparam logic [3:0] KIND_BEND   = 4'd5;
    localparam logic [3:0] KIND_SXBYTE = 4'd6;
    localparam logic [3:0] KIND_SXEND  = 4'd7;
    localparam logic [3:0] KIND_TC     = 4'd8;

    // Running message codes (status bits 6:4).
    localparam logic [2:0] MSG_NOTE_OFF = 3'd0;
    localparam logic [2:0] MSG_NOTE_ON  = 3'd1;
    localparam logic [2:0] MSG_POLY     = 3'd2;
    localparam logic [2:0] MSG_PROG     = 3'd4;
    localparam logic [2:0] MSG_CPRESS   = 3'd5;
    localparam logic [2:0] MSG_BEND     = 3'd6;
    localparam logic [2:0] MSG_SYSTEM   = 3'd7;

    // Special byte values.
    localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
    localparam logic [7:0] BYTE_QFRAME      = 8'hF1;
    localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;
    localparam logic [7:0] BYTE_REALTIME    = 8'hF8;
    localparam logic [7:0] BYTE_SUBID_RT    = 8'h7F;
    localparam logic [7:0] BYTE_SUBID_MTC   = 8'h01;

    // Frame rate codes and the time unit (1/600 s) per frame of each.
    localparam logic [1:0] RATE_24        = 2'd0;
    localparam logic [1:0] RATE_25        = 2'd1;
    localparam logic [4:0] TICKS_FRAME_24 = 5'd25;
    localparam logic [4:0] TICKS_FRAME_25 = 5'd24;
    localparam logic [4:0] TICKS_FRAME_30 = 5'd20;
    localparam int         TICKS_PER_SEC  = 600;
    localparam int         SECS_PER_MIN   = 60;
    localparam int         TIME_W         = 27;
    localparam logic [2:0] FULL_FRAME_LAST = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic decode;
        logic tc1;
        logic tc2;
        logic tc3;
        logic load_tc;
        logic load_evt;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic dec_tc;
        logic dec_evt;
        logic evt_pend;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/mbsp_ctrl.sv =====
// Controller state machine of the MIDI byte stream parser.
module mbsp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rx_valid,
    output logic            o_rx_stall,
    input  mbsp_pkg::t_sts  i_sts,
    output mbsp_pkg::t_cmd  o_cmd
);

    mbsp_pkg::t_state r_state;
    mbsp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbsp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mbsp_pkg::S_IDLE: begin
                if (i_rx_valid) n_state = mbsp_pkg::S_DECODE;
            end
            mbsp_pkg::S_DECODE: begin
                if (i_sts.dec_tc) begin
                    n_state = mbsp_pkg::S_TC1;
                end else if (i_sts.dec_evt) begin
                    n_state = mbsp_pkg::S_OUT_EVT;
                end else begin
                    n_state = mbsp_pkg::S_IDLE;
                end
            end
            mbsp_pkg::S_TC1: n_state = mbsp_pkg::S_TC2;
            mbsp_pkg::S_TC2: n_state = mbsp_pkg::S_TC3;
            mbsp_pkg::S_TC3: n_state = mbsp_pkg::S_OUT_TC;
            mbsp_pkg::S_OUT_TC: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.evt_pend ? mbsp_pkg::S_OUT_EVT : mbsp_pkg::S_IDLE;
                end
            end
            mbsp_pkg::S_OUT_EVT: begin
                if (i_sts.out_free) n_state = mbsp_pkg::S_IDLE;
            end
            default: n_state = mbsp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_rx_stall = 1'b1;
        unique case (r_state)
            mbsp_pkg::S_IDLE: begin
                o_rx_stall   = 1'b0;
                o_cmd.accept = i_rx_valid;
            end
            mbsp_pkg::S_DECODE:  o_cmd.decode   = 1'b1;
            mbsp_pkg::S_TC1:     o_cmd.tc1      = 1'b1;
            mbsp_pkg::S_TC2:     o_cmd.tc2      = 1'b1;
            mbsp_pkg::S_TC3:     o_cmd.tc3      = 1'b1;
            mbsp_pkg::S_OUT_TC:  o_cmd.load_tc  = i_sts.out_free;
            mbsp_pkg::S_OUT_EVT: o_cmd.load_evt = i_sts.out_free;
            default: ;
        endcase
    end

    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load_tc && o_cmd.load_evt))
        else $error("both result loads issued together");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_tc || o_cmd.load_evt) |-> i_sts.out_free)
        else $error("result loaded into an occupied output register");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == mbsp_pkg::S_DECODE))
        else $error("accepted byte not decoded next cycle");

    a_tc_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.tc1 |=> o_cmd.tc2 ##1 o_cmd.tc3)
        else $error("time computation steps out of order");

endmodule

// ===== sv/mbsp_dp.sv =====
// Datapath of the MIDI byte stream parser: parse state, time arithmetic, output register.
module mbsp_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_rx_byte,
    input  mbsp_pkg::t_cmd  i_cmd,
    output mbsp_pkg::t_sts  o_sts,
    input  logic            i_ev_stall,
    output logic            o_ev_valid,
    output logic [3:0]      o_event_kind,
    output logic [4:0]      o_midi_channel,
    output logic [6:0]      o_first_data,
    output logic [13:0]     o_event_value,
    output logic [1:0]      o_tc_rate,
    output logic [4:0]      o_tc_hours,
    output logic [7:0]      o_tc_minutes,
    output logic [7:0]      o_tc_seconds,
    output logic [7:0]      o_tc_frames,
    output logic            o_time_went_back,
    output logic            o_last_of_run
);

    localparam int TW = mbsp_pkg::TIME_W;

    // Parse state.
    logic [7:0]          r_byte;
    mbsp_pkg::t_mode     r_mode,      n_mode;
    logic [2:0]          r_run_msg,   n_run_msg;
    logic [4:0]          r_run_ch,    n_run_ch;
    logic [6:0]          r_held,      n_held;
    logic                r_held_vld,  n_held_vld;
    logic [2:0]          r_ff_idx,    n_ff_idx;
    logic [1:0]          r_rate,      n_rate;
    logic [4:0]          r_hours,     n_hours;
    logic [7:0]          r_minutes,   n_minutes;
    logic [7:0]          r_seconds,   n_seconds;
    logic [7:0]          r_frames,    n_frames;
    logic [TW-1:0]       r_prev;

    // Decode results.
    logic                dec_tc, dec_evt, tc_from_new;
    logic [3:0]          ev_kind;
    logic [4:0]          ev_ch;
    logic [6:0]          ev_fd;
    logic [13:0]         ev_val;

    // Pending event and time code snapshot.
    logic                r_evt_pend;
    logic [3:0]          r_ev_kind;
    logic [4:0]          r_ev_ch;
    logic [6:0]          r_ev_fd;
    logic [13:0]         r_ev_val;
    logic [1:0]          r_tc_rate;
    logic [4:0]          r_tc_hours;
    logic [7:0]          r_tc_minutes;
    logic [7:0]          r_tc_seconds;
    logic [7:0]          r_tc_frames;

    // Time arithmetic.
    logic [16:0]         r_acc;
    logic [12:0]         r_fu;
    logic                r_back;
    logic [4:0]          unit;
    logic [TW-1:0]       t_now;

    // Output register.
    logic                r_o_valid;
    logic [3:0]          r_o_kind;
    logic [4:0]          r_o_ch;
    logic [6:0]          r_o_fd;
    logic [13:0]         r_o_val;
    logic [1:0]          r_o_rate;
    logic [4:0]          r_o_hours;
    logic [7:0]          r_o_minutes;
    logic [7:0]          r_o_seconds;
    logic [7:0]          r_o_frames;
    logic                r_o_back;
    logic                r_o_last;

    always_comb begin
        n_mode     = r_mode;
        n_run_msg  = r_run_msg;
        n_run_ch   = r_run_ch;
        n_held     = r_held;
        n_held_vld = r_held_vld;
        n_ff_idx   = r_ff_idx;
        n_rate     = r_rate;
        n_hours    = r_hours;
        n_minutes  = r_minutes;
        n_seconds  = r_seconds;
        n_frames   = r_frames;
        dec_tc      = 1'b0;
        dec_evt     = 1'b0;
        tc_from_new = 1'b0;
        ev_kind     = mbsp_pkg::KIND_NOTE;
        ev_ch       = r_run_ch;
        ev_fd       = '0;
        ev_val      = '0;
        // Real-time bytes leave every piece of state alone.
        if (r_byte < mbsp_pkg::BYTE_REALTIME) begin
            case (r_mode) inside
                mbsp_pkg::MODE_QFRAME: begin
                    n_mode = mbsp_pkg::MODE_NORMAL;
                    case (r_byte[7:4])
                        4'd0: begin
                            dec_tc   = 1'b1;
                            n_frames = {r_frames[7:4], r_byte[3:0]};
                        end
                        4'd1: n_frames  = {r_byte[3:0], r_frames[3:0]};
                        4'd2: n_seconds = {r_seconds[7:4], r_byte[3:0]};
                        4'd3: n_seconds = {r_byte[3:0], r_seconds[3:0]};
                        4'd4: n_minutes = {r_minutes[7:4], r_byte[3:0]};
                        4'd5: n_minutes = {r_byte[3:0], r_minutes[3:0]};
                        4'd6: n_hours   = {r_hours[4], r_byte[3:0]};
                        4'd7: begin
                            n_hours = {r_byte[0], r_hours[3:0]};
                            n_rate  = r_byte[2:1];
                        end
                        default: ;
                    endcase
                end
                mbsp_pkg::MODE_SYSEX: begin
                    if (r_byte == mbsp_pkg::BYTE_SYSEX_END) begin
                        n_mode  = mbsp_pkg::MODE_NORMAL;
                        dec_evt = 1'b1;
                        ev_kind = mbsp_pkg::KIND_SXEND;
                        ev_ch   = '0;
                    end else if (r_byte == mbsp_pkg::BYTE_SUBID_RT) begin
                        n_mode = mbsp_pkg::MODE_SX_RT;
                    end
                end
                mbsp_pkg::MODE_SX_RT, mbsp_pkg::MODE_SX_MTC: begin
                    dec_evt = 1'b1;
                    ev_ch   = '0;
                    if (r_byte == mbsp_pkg::BYTE_SYSEX_END) begin
                        n_mode  = mbsp_pkg::MODE_NORMAL;
                        ev_kind = mbsp_pkg::KIND_SXEND;
                    end else begin
                        ev_kind = mbsp_pkg::KIND_SXBYTE;
                        ev_val  = {6'd0, r_byte};
                        if (r_byte == mbsp_pkg::BYTE_SUBID_MTC) begin
                            if (r_mode == mbsp_pkg::MODE_SX_RT) begin
                                n_mode = mbsp_pkg::MODE_SX_MTC;
                            end else begin
                                n_mode   = mbsp_pkg::MODE_SX_FULL;
                                n_ff_idx = '0;
                            end
                        end
                    end
                end
                mbsp_pkg::MODE_SX_FULL: begin
                    case (r_ff_idx)
                        3'd0: begin
                            n_rate  = r_byte[6:5];
                            n_hours = r_byte[4:0];
                        end
                        3'd1: n_minutes = r_byte;
                        3'd2: n_seconds = r_byte;
                        3'd3: n_frames  = r_byte;
                        default: ;
                    endcase
                    if (r_ff_idx < mbsp_pkg::FULL_FRAME_LAST) n_ff_idx = r_ff_idx + 3'd1;
                    dec_evt = 1'b1;
                    ev_ch   = '0;
                    if (r_byte == mbsp_pkg::BYTE_SYSEX_END) begin
                        // Time code first, built from the fields just stored.
                        dec_tc      = 1'b1;
                        tc_from_new = 1'b1;
                        ev_kind     = mbsp_pkg::KIND_SXEND;
                        n_mode      = mbsp_pkg::MODE_NORMAL;
                    end else begin
                        ev_kind = mbsp_pkg::KIND_SXBYTE;
                        ev_val  = {6'd0, r_byte};
                    end
                end
                default: begin
                    n_mode = mbsp_pkg::MODE_NORMAL;
                    if (r_byte == mbsp_pkg::BYTE_QFRAME) begin
                        n_mode = mbsp_pkg::MODE_QFRAME;
                    end else if (r_byte == mbsp_pkg::BYTE_SYSEX_START) begin
                        n_mode = mbsp_pkg::MODE_SYSEX;
                    end else if (r_byte[7]) begin
                        n_run_msg  = r_byte[6:4];
                        n_run_ch   = {1'b0, r_byte[3:0]} + 5'd1;
                        n_held_vld = 1'b0;
                    end else begin
                        case (r_run_msg)
                            mbsp_pkg::MSG_PROG: begin
                                dec_evt = 1'b1;
                                ev_kind = mbsp_pkg::KIND_PROG;
                                ev_val  = {7'd0, r_byte[6:0]};
                            end
                            mbsp_pkg::MSG_CPRESS: begin
                                dec_evt = 1'b1;
                                ev_kind = mbsp_pkg::KIND_CPRESS;
                                ev_val  = {7'd0, r_byte[6:0]};
                            end
                            mbsp_pkg::MSG_SYSTEM: ;
                            default: begin
                                if (!r_held_vld) begin
                                    n_held     = r_byte[6:0];
                                    n_held_vld = 1'b1;
                                end else begin
                                    n_held_vld = 1'b0;
                                    dec_evt    = 1'b1;
                                    ev_fd      = r_held;
                                    ev_val     = {7'd0, r_byte[6:0]};
                                    case (r_run_msg)
                                        mbsp_pkg::MSG_NOTE_OFF: begin
                                            ev_kind = mbsp_pkg::KIND_NOTE;
                                            ev_val  = '0;
                                        end
                                        mbsp_pkg::MSG_BEND: begin
                                            ev_kind = mbsp_pkg::KIND_BEND;
                                            ev_fd   = '0;
                                            ev_val  = {r_byte[6:0], r_held};
                                        end
                                        mbsp_pkg::MSG_NOTE_ON: ev_kind = mbsp_pkg::KIND_NOTE;
                                        mbsp_pkg::MSG_POLY:    ev_kind = mbsp_pkg::KIND_POLY;
                                        default:               ev_kind = mbsp_pkg::KIND_CTRL;
                                    endcase
                                end
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_comb begin
        unique case (r_tc_rate)
            mbsp_pkg::RATE_24: unit = mbsp_pkg::TICKS_FRAME_24;
            mbsp_pkg::RATE_25: unit = mbsp_pkg::TICKS_FRAME_25;
            default:           unit = mbsp_pkg::TICKS_FRAME_30;
        endcase
    end

    assign t_now = TW'(r_acc) * TW'(mbsp_pkg::TICKS_PER_SEC) + TW'(r_fu);

    // Control state of the parser.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= mbsp_pkg::MODE_NORMAL;
            r_run_msg  <= mbsp_pkg::MSG_NOTE_OFF;
            r_run_ch   <= '0;
            r_held     <= '0;
            r_held_vld <= 1'b0;
            r_ff_idx   <= '0;
            r_rate     <= '0;
            r_hours    <= '0;
            r_minutes  <= '0;
            r_seconds  <= '0;
            r_frames   <= '0;
            r_prev     <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cmd.decode) begin
                r_mode     <= n_mode;
                r_run_msg  <= n_run_msg;
                r_run_ch   <= n_run_ch;
                r_held     <= n_held;
                r_held_vld <= n_held_vld;
                r_ff_idx   <= n_ff_idx;
                r_rate     <= n_rate;
                r_hours    <= n_hours;
                r_minutes  <= n_minutes;
                r_seconds  <= n_seconds;
                r_frames   <= n_frames;
            end
            if (i_cmd.tc3) r_prev <= t_now;
            if (i_cmd.load_tc || i_cmd.load_evt) begin
                r_o_valid <= 1'b1;
            end else if (!i_ev_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_byte <= i_rx_byte;
        if (i_cmd.decode) begin
            r_evt_pend <= dec_evt;
            r_ev_kind  <= ev_kind;
            r_ev_ch    <= ev_ch;
            r_ev_fd    <= ev_fd;
            r_ev_val   <= ev_val;
            if (tc_from_new) begin
                r_tc_rate    <= n_rate;
                r_tc_hours   <= n_hours;
                r_tc_minutes <= n_minutes;
                r_tc_seconds <= n_seconds;
                r_tc_frames  <= n_frames;
            end else begin
                r_tc_rate    <= r_rate;
                r_tc_hours   <= r_hours;
                r_tc_minutes <= r_minutes;
                r_tc_seconds <= r_seconds;
                r_tc_frames  <= r_frames;
            end
        end
        if (i_cmd.tc1) begin
            r_acc <= 17'(12'(r_tc_hours) * 12'(mbsp_pkg::SECS_PER_MIN) + 12'(r_tc_minutes));
            r_fu  <= ({5'd0, r_tc_frames} + 13'd2) * 13'(unit);
        end
        if (i_cmd.tc2) begin
            r_acc <= r_acc * 17'(mbsp_pkg::SECS_PER_MIN) + 17'(r_tc_seconds);
        end
        if (i_cmd.tc3) r_back <= (t_now < r_prev);
        if (i_cmd.load_tc) begin
            r_o_kind    <= mbsp_pkg::KIND_TC;
            r_o_ch      <= '0;
            r_o_fd      <= '0;
            r_o_val     <= '0;
            r_o_rate    <= r_tc_rate;
            r_o_hours   <= r_tc_hours;
            r_o_minutes <= r_tc_minutes;
            r_o_seconds <= r_tc_seconds;
            r_o_frames  <= r_tc_frames;
            r_o_back    <= r_back;
            r_o_last    <= !r_evt_pend;
        end else if (i_cmd.load_evt) begin
            r_o_kind    <= r_ev_kind;
            r_o_ch      <= r_ev_ch;
            r_o_fd      <= r_ev_fd;
            r_o_val     <= r_ev_val;
            r_o_rate    <= '0;
            r_o_hours   <= '0;
            r_o_minutes <= '0;
            r_o_seconds <= '0;
            r_o_frames  <= '0;
            r_o_back    <= 1'b0;
            r_o_last    <= 1'b1;
        end
    end

    assign o_sts.dec_tc   = dec_tc;
    assign o_sts.dec_evt  = dec_evt;
    assign o_sts.evt_pend = r_evt_pend;
    assign o_sts.out_free = !r_o_valid || !i_ev_stall;

    assign o_ev_valid       = r_o_valid;
    assign o_event_kind     = r_o_kind;
    assign o_midi_channel   = r_o_ch;
    assign o_first_data     = r_o_fd;
    assign o_event_value    = r_o_val;
    assign o_tc_rate        = r_o_rate;
    assign o_tc_hours       = r_o_hours;
    assign o_tc_minutes     = r_o_minutes;
    assign o_tc_seconds     = r_o_seconds;
    assign o_tc_frames      = r_o_frames;
    assign o_time_went_back = r_o_back;
    assign o_last_of_run    = r_o_last;

endmodule

// ===== sv/midi_byte_stream_parser_unit.sv =====
// Top level of the MIDI byte stream parser: controller plus datapath.
//
//  Channel   Direction  Handshake                Payload
//  rx        in         i_rx_valid / o_rx_stall  i_rx_byte
//  ev        out        o_ev_valid / i_ev_stall  o_event_kind ... o_last_of_run
//
//  A byte with no result goes through decode only; a channel or sysex event
//  then goes to the event output state. A time code result goes through the
//  three-step constant multiply chain that forms the 1/600 s time; a sysex end
//  after it is output next. A stalled output register holds results and input.
//  Reset is synchronous; after it the parser is in normal mode, note-off, channel 0.
module midi_byte_stream_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_ev_valid,
    input  logic        i_ev_stall,
    output logic [3:0]  o_event_kind,
    output logic [4:0]  o_midi_channel,
    output logic [6:0]  o_first_data,
    output logic [13:0] o_event_value,
    output logic [1:0]  o_tc_rate,
    output logic [4:0]  o_tc_hours,
    output logic [7:0]  o_tc_minutes,
    output logic [7:0]  o_tc_seconds,
    output logic [7:0]  o_tc_frames,
    output logic        o_time_went_back,
    output logic        o_last_of_run
);

    mbsp_pkg::t_cmd cmd;
    mbsp_pkg::t_sts sts;

    mbsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_stall (o_rx_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mbsp_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_byte        (i_rx_byte),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_ev_stall       (i_ev_stall),
        .o_ev_valid       (o_ev_valid),
        .o_event_kind     (o_event_kind),
        .o_midi_channel   (o_midi_channel),
        .o_first_data     (o_first_data),
        .o_event_value    (o_event_value),
        .o_tc_rate        (o_tc_rate),
        .o_tc_hours       (o_tc_hours),
        .o_tc_minutes     (o_tc_minutes),
        .o_tc_seconds     (o_tc_seconds),
        .o_tc_frames      (o_tc_frames),
        .o_time_went_back (o_time_went_back),
        .o_last_of_run    (o_last_of_run)
    );

endmodule
